// ===== rtl/mpsm_pkg.sv =====
package mpsm_pkg;

   localparam int NUM_PATTERNS_DEF = 16;
   localparam int MAX_LEN_DEF      = 32;

   localparam logic [1:0] OP_STREAM  = 2'd0;
   localparam logic [1:0] OP_PAT_BYTE = 2'd1;
   localparam logic [1:0] OP_PAT_LEN  = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   localparam logic CSR_ONCE_MODE = 1'b0;
   localparam logic CSR_PAT_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic       stream_end;
      logic [3:0] slot;
      logic [4:0] position;
      logic [5:0] length;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [3:0] match_slot;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_FLUSH
   } eng_state_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

endpackage

// ===== rtl/mpsm_fifo.sv =====
module mpsm_fifo import mpsm_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  req_type in_word,
   output logic    out_valid,
   input  logic    out_take,
   output req_type out_word
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           push, pop;

   assign in_stall  = (cnt_ff == AW'(0) + (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_word  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && out_take;

   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_word;
   end
endmodule

// ===== rtl/mpsm_engine.sv =====
module mpsm_engine import mpsm_pkg::*; #(
   parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
   parameter int MAX_LEN      = MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       once_mode,
   input  logic [4:0] pattern_count,
   input  logic       in_valid,
   output logic       in_take,
   input  req_type    in_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_word
);
   localparam int SW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int CW = $clog2(NUM_PATTERNS + 1);
   localparam int MD = NUM_PATTERNS * MAX_LEN;
   localparam int MA = (MD > 1) ? $clog2(MD) : 1;

   eng_state_type state_ff, state_in;

   logic [7:0]        win_ff [MAX_LEN];
   logic [PW-1:0]     head_ff, head_in;
   logic [LW-1:0]     fill_ff, fill_in;
   logic [7:0]        pmem [MD];
   logic [7:0]        prd_ff;
   logic [LW-1:0]     plen_ff [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0] used_ff, used_in;
   logic              all_used_ff, all_used_in;
   logic [SW:0]       s_ff, s_in;
   logic [LW-1:0]     k_ff, k_in;
   logic              end_ff, end_in;
   logic              out_v_ff;
   rsp_type           out_ff;
   logic              emit;
   rsp_type           emit_word;
   logic              out_free;

   logic [CW-1:0]     pcnt;
   logic [SW-1:0]     s_idx;
   logic [LW-1:0]     cur_len;
   logic              elig;
   logic [PW-1:0]     widx;
   logic [PW-1:0]     wptr;
   logic [PW-1:0]     head_adv;
   logic [31:0]       widx_sum;
   logic [31:0]       wptr_sum;
   logic [31:0]       adv_sum;
   logic [7:0]        wbyte;
   logic [MA-1:0]     raddr;
   logic              req_stream;
   logic              last_done;
   logic [LW-1:0]     pl_sat;

   assign pcnt  = (32'(pattern_count) > NUM_PATTERNS) ? CW'(NUM_PATTERNS)
                                                      : CW'(pattern_count);
   assign s_idx   = s_ff[SW-1:0];
   assign cur_len = plen_ff[s_idx];
   assign elig    = (cur_len != '0) && !all_used_ff && !(once_mode && used_ff[s_idx]);
   // window offsets wrap around the circular buffer
   assign widx_sum = 32'(head_ff) + 32'(k_ff);
   assign widx     = PW'((widx_sum >= 32'(MAX_LEN)) ? widx_sum - 32'(MAX_LEN) : widx_sum);
   assign wptr_sum = 32'(head_ff) + 32'(fill_ff);
   assign wptr     = PW'((wptr_sum >= 32'(MAX_LEN)) ? wptr_sum - 32'(MAX_LEN) : wptr_sum);
   assign adv_sum  = 32'(head_ff) + 32'(cur_len);
   assign head_adv = PW'((adv_sum >= 32'(MAX_LEN)) ? adv_sum - 32'(MAX_LEN) : adv_sum);
   assign wbyte   = win_ff[widx];
   assign out_free = !out_v_ff || !rsp_stall;
   assign req_stream = in_word.opcode == OP_STREAM;
   assign pl_sat = (32'(in_word.length) > MAX_LEN) ? LW'(MAX_LEN) : LW'(in_word.length);
   assign raddr  = MA'(32'(s_idx) * MAX_LEN + 32'(k_in));
   assign last_done = end_ff && (fill_ff == LW'(1));

   // outputs of the current state
   always_comb begin
      in_take   = 1'b0;
      emit      = 1'b0;
      emit_word = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_take = in_valid;
         end
         ST_SCAN: begin
            // every slot declined: pass oldest byte
            if (fill_ff != '0 && 32'(s_ff) >= 32'(pcnt) && out_free) begin
               emit = 1'b1;
               emit_word.out_byte = win_ff[head_ff];
               emit_word.last = last_done;
            end
         end
         ST_CMP: begin
            if (k_ff == cur_len && out_free) begin
               emit = 1'b1;
               emit_word.kind = 1'b1;
               emit_word.match_slot = 4'(s_idx);
               emit_word.last = end_ff && (fill_ff == cur_len);
            end
         end
         ST_FLUSH: begin
            if (fill_ff != '0 && out_free) begin
               emit = 1'b1;
               emit_word.out_byte = win_ff[head_ff];
               emit_word.last = fill_ff == LW'(1);
            end
         end
         default: ;
      endcase
   end

   // next state; one step per cycle while the output register is not stalled
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      used_in     = used_ff;
      all_used_in = all_used_ff;
      s_in        = s_ff;
      k_in        = k_ff;
      end_in      = end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid && req_stream) begin
               end_in = in_word.stream_end;
               if (32'(fill_ff) < MAX_LEN) fill_in = fill_ff + 1'b1;
               s_in = '0;
               k_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            k_in = '0;
            if (fill_ff == '0) begin
               state_in = ST_IDLE;
               if (end_ff) begin
                  used_in = '0;
                  all_used_in = 1'b0;
               end
            end else if (32'(s_ff) >= 32'(pcnt)) begin
               if (emit) begin
                  head_in = (32'(head_ff) == MAX_LEN-1) ? '0 : head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
                  s_in = '0;
               end
            end else if (!elig) begin
               s_in = s_ff + 1'b1;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (k_ff == cur_len) begin
               if (emit) begin
                  head_in = head_adv;
                  fill_in = fill_ff - cur_len;
                  used_in[s_idx] = 1'b1;
                  if (once_mode) begin
                     all_used_in = 1'b1;
                     for (int i = 0; i < NUM_PATTERNS; i++)
                        if (i < 32'(pcnt) && plen_ff[i] != '0 && !used_in[i])
                           all_used_in = 1'b0;
                  end
                  s_in = '0;
                  state_in = ST_SCAN;
               end
            end else if (k_ff == fill_ff) begin
               // partial match waits, or is cut off at stream end
               state_in = end_ff ? ST_FLUSH : ST_IDLE;
            end else if (fold(wbyte) == prd_ff) begin
               k_in = k_ff + 1'b1;
            end else begin
               s_in = s_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (fill_ff == '0) begin
               state_in = ST_IDLE;
               used_in = '0;
               all_used_in = 1'b0;
            end else if (emit) begin
               head_in = (32'(head_ff) == MAX_LEN-1) ? '0 : head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         fill_ff     <= '0;
         used_ff     <= '0;
         all_used_ff <= 1'b0;
         s_ff        <= '0;
         k_ff        <= '0;
         end_ff      <= 1'b0;
         out_v_ff    <= 1'b0;
         for (int i = 0; i < NUM_PATTERNS; i++) plen_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         used_ff     <= used_in;
         all_used_ff <= all_used_in;
         s_ff        <= s_in;
         k_ff        <= k_in;
         end_ff      <= end_in;
         if (emit) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         if (in_take && in_word.opcode == OP_PAT_LEN && 32'(in_word.slot) < NUM_PATTERNS)
            plen_ff[SW'(in_word.slot)] <= pl_sat;
      end
      if (emit) out_ff <= emit_word;
      if (in_take && req_stream && 32'(fill_ff) < MAX_LEN)
         win_ff[wptr] <= in_word.data_byte;
      if (in_take && in_word.opcode == OP_PAT_BYTE && 32'(in_word.slot) < NUM_PATTERNS
          && 32'(in_word.position) < MAX_LEN)
         pmem[MA'(32'(in_word.slot) * MAX_LEN + 32'(in_word.position))] <= in_word.data_byte;
      prd_ff <= pmem[raddr];
   end

   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;
endmodule

// ===== rtl/multi_pattern_substring_matcher_top.sv =====
// Streaming multi-pattern matcher: stream words enter a 4-entry queue; the
// engine then scans one comparison step per cycle, while the output is not
// stalled, at the oldest undecided position, trying slots in order, and emits
// literal or match-token words through a one-word output register. A stream
// word is handled by accepting it, trying each slot, comparing each pattern
// byte, emitting each result and a closing step (a partial match that waits
// for more bytes ends without it); the pace is set by the single-ported
// pattern memory, read once per cycle. Load words are accepted from idle.
module multi_pattern_substring_matcher_top import mpsm_pkg::*; #(
   parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
   parameter int MAX_LEN      = MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_word,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [4:0] csr_data
);
   logic       once_ff;
   logic [4:0] count_ff;
   logic       q_valid, q_take;
   req_type    q_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         once_ff  <= 1'b1;
         count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ONCE_MODE: once_ff <= csr_data[0];
            CSR_PAT_COUNT: count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mpsm_fifo #(.DEPTH(4)) u_fifo (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_word(req_word),
      .out_valid(q_valid), .out_take(q_take), .out_word(q_word)
   );

   mpsm_engine #(.NUM_PATTERNS(NUM_PATTERNS), .MAX_LEN(MAX_LEN)) u_engine (
      .clock, .reset,
      .once_mode(once_ff), .pattern_count(count_ff),
      .in_valid(q_valid), .in_take(q_take), .in_word(q_word),
      .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule

// ===== tb/multi_pattern_substring_matcher_top_tb.sv =====
module multi_pattern_substring_matcher_top_tb;
   import mpsm_pkg::*;

   localparam int SLOTS   = 16;
   localparam int MAXLEN  = 32;
   localparam int LIMIT   = 1500000;
   localparam int SETTLE  = 64;
   localparam int PHASE_SLOTS = 4;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_word;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_word;
   logic       csr_write;
   logic       csr_index;
   logic [4:0] csr_data;

   multi_pattern_substring_matcher_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   req_type    pending_words[$];
   rsp_type    expected_tokens[$];
   bit         failed;
   bit         burst;
   bit         req_taken;
   int         send_gap;
   int         stall_left;
   int         cycles;

   // matcher state mirror
   logic [7:0] win_bytes[MAXLEN];
   int         win_fill;
   logic [7:0] pat_bytes[SLOTS][MAXLEN];
   int         pat_len[SLOTS];
   bit         used[SLOTS];
   bit         all_used;
   bit         once_mode;
   int         pat_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] lower(logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic void emit_token(bit kind, logic [7:0] b, int s);
      rsp_type r;
      r.kind       = kind;
      r.out_byte   = kind ? 8'd0 : b;
      r.match_slot = kind ? 4'(s) : 4'd0;
      r.last       = 1'b0;
      expected_tokens.push_back(r);
   endfunction

   function automatic void shift_window(int n);
      if (n >= win_fill) begin
         win_fill = 0;
         return;
      end
      for (int i = 0; i < win_fill - n; i++) win_bytes[i] = win_bytes[i + n];
      win_fill -= n;
   endfunction

   function automatic void match_word(req_type w);
      bit waiting;
      bit matched;
      bit done;
      int k;
      int produced;
      waiting  = 0;
      produced = 0;
      case (w.opcode)
         OP_PAT_BYTE: begin
            pat_bytes[w.slot][w.position] = w.data_byte;
            return;
         end
         OP_PAT_LEN: begin
            pat_len[w.slot] = (w.length > MAXLEN) ? MAXLEN : int'(w.length);
            return;
         end
         OP_STREAM: ;
         default: return;
      endcase
      if (win_fill < MAXLEN) begin
         win_bytes[win_fill] = w.data_byte;
         win_fill++;
      end
      while (win_fill > 0 && !waiting) begin
         matched = 0;
         done    = 0;
         for (int s = 0; s < pat_count && !done; s++) begin
            if (pat_len[s] == 0 || all_used || (once_mode && used[s])) continue;
            k = 0;
            while (k < pat_len[s] && k < win_fill &&
                   lower(win_bytes[k]) == pat_bytes[s][k]) k++;
            if (k == pat_len[s]) begin
               emit_token(1, 8'd0, s);
               produced++;
               shift_window(pat_len[s]);
               used[s] = 1;
               if (once_mode) begin
                  all_used = 1;
                  for (int t = 0; t < pat_count; t++)
                     if (pat_len[t] != 0 && !used[t]) all_used = 0;
               end
               matched = 1;
               done    = 1;
            end else if (k == win_fill) begin
               waiting = 1;
               done    = 1;
            end
         end
         if (!matched && !waiting) begin
            emit_token(0, win_bytes[0], 0);
            produced++;
            shift_window(1);
         end
      end
      if (w.stream_end) begin
         // flush whatever a pending partial match still holds
         for (int i = 0; i < win_fill; i++) begin
            emit_token(0, win_bytes[i], 0);
            produced++;
         end
         win_fill = 0;
         for (int s = 0; s < SLOTS; s++) used[s] = 0;
         all_used = 0;
         if (produced > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
   endfunction

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled word
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_words.size() > 0) begin
         req_word  <= pending_words.pop_front();
         req_valid <= 1'b1;
         send_gap  = burst ? 0 : $urandom_range(0, 4);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("[multi_pattern_substring_matcher_top] ERROR");
         $finish;
      end
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (csr_write) begin
            if (csr_index == CSR_ONCE_MODE) once_mode = csr_data[0];
            else pat_count = (csr_data > SLOTS) ? SLOTS : int'(csr_data);
         end
         if (req_valid && !req_stall) match_word(req_word);
         if (rsp_valid && !rsp_stall) begin
            stall_left = burst ? 0 : $urandom_range(0, 4);
            if (expected_tokens.size() == 0) begin
               $error("unexpected word kind %0d byte %0h slot %0d", rsp_word.kind,
                      rsp_word.out_byte, rsp_word.match_slot);
               failed = 1;
            end else begin
               e = expected_tokens.pop_front();
               if (rsp_word.kind !== e.kind) begin
                  $error("kind expected %0d actual %0d", e.kind, rsp_word.kind);
                  failed = 1;
               end
               if (rsp_word.out_byte !== e.out_byte) begin
                  $error("out_byte expected %0h actual %0h", e.out_byte, rsp_word.out_byte);
                  failed = 1;
               end
               if (rsp_word.match_slot !== e.match_slot) begin
                  $error("match_slot expected %0d actual %0d", e.match_slot,
                         rsp_word.match_slot);
                  failed = 1;
               end
               if (rsp_word.last !== e.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_word.last);
                  failed = 1;
               end
            end
         end
      end
   end

   function automatic req_type noise_word();
      req_type w;
      w = req_type'($urandom);
      return w;
   endfunction

   task automatic push_byte(logic [7:0] b, bit last_byte);
      req_type w;
      w = noise_word();
      w.opcode     = OP_STREAM;
      w.data_byte  = b;
      w.stream_end = last_byte;
      pending_words.push_back(w);
   endtask

   task automatic push_pat(int s, int p, logic [7:0] b);
      req_type w;
      w = noise_word();
      w.opcode    = OP_PAT_BYTE;
      w.slot      = 4'(s);
      w.position  = 5'(p);
      w.data_byte = b;
      pending_words.push_back(w);
   endtask

   task automatic push_len(int s, int n);
      req_type w;
      w = noise_word();
      w.opcode = OP_PAT_LEN;
      w.slot   = 4'(s);
      w.length = 6'(n);
      pending_words.push_back(w);
   endtask

   task automatic load_pattern(int s, string txt);
      for (int i = 0; i < txt.len(); i++) push_pat(s, i, txt[i]);
      push_len(s, txt.len());
   endtask

   task automatic push_text(string txt);
      for (int i = 0; i < txt.len(); i++) push_byte(txt[i], i == txt.len() - 1);
   endtask

   function automatic logic [7:0] stream_char();
      string alpha;
      alpha = "abcABC";
      if ($urandom_range(0, 9) < 8) return alpha[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_tokens.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      req_type w;
      int n;
      int budget;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      rsp_stall  = 1'b0;
      csr_write  = 1'b0;
      csr_index  = 1'b0;
      csr_data   = '0;
      burst      = 0;
      once_mode  = 1;
      pat_count  = 0;
      win_fill   = 0;
      all_used   = 0;
      for (int s = 0; s < SLOTS; s++) begin
         pat_len[s] = 0;
         used[s]    = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: priority, case folding, saturation, once mode, cut off at end
      write_csr(CSR_ONCE_MODE, 5'd1);
      write_csr(CSR_PAT_COUNT, 5'd31);
      load_pattern(0, "abc");
      load_pattern(1, "ab");
      load_pattern(2, "z");
      // long slot that always fails on its first byte
      push_pat(3, 0, "q");
      push_len(3, 40);
      push_text("AbCaBzZ@[");
      push_byte(8'h00, 0);
      push_byte(8'hFF, 1);
      w = noise_word();
      w.opcode = OP_NONE;
      pending_words.push_back(w);
      drain();
      write_csr(CSR_PAT_COUNT, 5'd2);
      push_text("abcabab");
      push_text("a");
      drain();
      write_csr(CSR_ONCE_MODE, 5'd0);
      push_text("xababcab");
      // pattern length cleared to zero while the stream is running
      push_byte("a", 0);
      push_len(1, 0);
      push_byte("b", 1);
      drain();
      // every enabled slot used, then once mode cleared mid-stream
      write_csr(CSR_ONCE_MODE, 5'd1);
      push_len(1, 2);
      push_byte("a", 0);
      push_byte("b", 0);
      push_byte("c", 0);
      push_byte("a", 0);
      push_byte("b", 0);
      drain();
      write_csr(CSR_ONCE_MODE, 5'd0);
      push_text("ababc");
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_ONCE_MODE, 5'($urandom) | 5'(phase % 2));
         case (phase)
            0: write_csr(CSR_PAT_COUNT, 5'd16);
            1: write_csr(CSR_PAT_COUNT, 5'd0);
            2: write_csr(CSR_PAT_COUNT, 5'd31);
            default: write_csr(CSR_PAT_COUNT, 5'($urandom_range(1, 20)));
         endcase
         for (int s = 0; s < PHASE_SLOTS; s++) begin
            n = $urandom_range(0, 19);
            n = (n < 4) ? 0 : (n < 19) ? $urandom_range(1, 4) : $urandom_range(32, 40);
            for (int p = 0; p < n && p < MAXLEN; p++)
               push_pat(s, p, ($urandom_range(0, 19) == 0) ? 8'($urandom) :
                        8'($urandom_range(97, 99)));
            push_len(s, n);
         end
         burst  = (phase == 3);
         budget = 8;
         while (budget > 0) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  w = noise_word();
                  if (w.opcode == OP_STREAM) w.opcode = OP_NONE;
                  if (w.opcode == OP_PAT_LEN) w.length = '0;
                  pending_words.push_back(w);
               end
               push_byte(stream_char(), i == n - 1);
               budget--;
            end
            // in phase 2, pause the sender once the phase is half issued
            if (phase == 2 && budget < 4 && budget + n >= 4)
               while (pending_words.size() > 0 || req_valid || expected_tokens.size() > 0)
                  @(posedge clock);
         end
         drain();
      end

      if (!failed)
         $display("[multi_pattern_substring_matcher_top] OK");
      else
         $display("[multi_pattern_substring_matcher_top] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mpsm_pkg.sv
rtl/mpsm_fifo.sv
rtl/mpsm_engine.sv
rtl/multi_pattern_substring_matcher_top.sv
tb/multi_pattern_substring_matcher_top_tb.sv
